@@ src/thtu_pkg.sv @@
// Shared types and constants for the timed hysteresis trigger.
`default_nettype none

package thtu_pkg;

    localparam int TIME_W  = 63;
    localparam int VALUE_W = 32;
    localparam int DELAY_W = 48;
    localparam int CFG_W   = 48;

    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 128;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RISE_LEVEL = 2'd0,
        REG_FALL_LEVEL = 2'd1,
        REG_ON_DELAY   = 2'd2,
        REG_OFF_DELAY  = 2'd3
    } cfg_reg_t;

    // Item kinds carried in tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] rise_level;
        logic signed [VALUE_W-1:0] fall_level;
        logic        [DELAY_W-1:0] on_delay;
        logic        [DELAY_W-1:0] off_delay;
    } cfg_t;

    typedef struct packed {
        logic                      kind;
        logic        [TIME_W-1:0]  sample_time;
        logic signed [VALUE_W-1:0] sample_value;
        logic                      load_active;
        logic        [TIME_W-1:0]  load_switch_time;
        logic        [TIME_W-1:0]  load_edge_time;
    } item_t;

    typedef struct packed {
        logic              active;
        logic [TIME_W-1:0] switch_time;
        logic [TIME_W-1:0] edge_time;
    } result_t;

    // Present trigger and arming state, seen by the top level
    typedef struct packed {
        logic trigger;
        logic rise_armed;
        logic fall_armed;
    } status_t;

endpackage

`default_nettype wire

@@ src/thtu_cfg.sv @@
// Configuration register file: thresholds and dwell delays.
`default_nettype none

module thtu_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [thtu_pkg::CFG_W-1:0]  cfg_data,
    output thtu_pkg::cfg_t                   cfg
);

    thtu_pkg::cfg_t cfg_reg;
    thtu_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (thtu_pkg::cfg_reg_t'(cfg_index))
                thtu_pkg::REG_RISE_LEVEL:
                    cfg_next.rise_level = cfg_data[thtu_pkg::VALUE_W-1:0];
                thtu_pkg::REG_FALL_LEVEL:
                    cfg_next.fall_level = cfg_data[thtu_pkg::VALUE_W-1:0];
                thtu_pkg::REG_ON_DELAY:
                    cfg_next.on_delay   = cfg_data[thtu_pkg::DELAY_W-1:0];
                thtu_pkg::REG_OFF_DELAY:
                    cfg_next.off_delay  = cfg_data[thtu_pkg::DELAY_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ src/thtu_core.sv @@
// Trigger state and the combinational update for one sample or load beat.
`default_nettype none

module thtu_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire thtu_pkg::item_t item,
    input  wire thtu_pkg::cfg_t  cfg,
    output thtu_pkg::result_t    result,
    output thtu_pkg::status_t    status
);

    localparam int T = thtu_pkg::TIME_W;

    logic         trigger_reg,     trigger_next;
    logic [T-1:0] switch_time_reg, switch_time_next;
    logic [T-1:0] edge_time_reg,   edge_time_next;
    logic         rise_armed_reg,  rise_armed_next;
    logic         fall_armed_reg,  fall_armed_next;
    logic [T-1:0] rise_start_reg,  rise_start_next;
    logic [T-1:0] fall_start_reg,  fall_start_next;

    logic                            armed;
    logic                            crossed;
    logic [T-1:0]                    start;
    logic [thtu_pkg::DELAY_W-1:0]    delay;
    logic [T:0]                      elapsed;
    logic                            reached;

    // Only the side facing away from the present trigger state is live
    always_comb
    begin
        armed   = trigger_reg ? fall_armed_reg : rise_armed_reg;
        crossed = trigger_reg ? (item.sample_value <= cfg.fall_level)
                              : (item.sample_value >= cfg.rise_level);
        start   = armed ? (trigger_reg ? fall_start_reg : rise_start_reg)
                        : item.sample_time;
        delay   = trigger_reg ? cfg.off_delay : cfg.on_delay;
        elapsed = {1'b0, item.sample_time} - {1'b0, start};
        // Borrow out means time ran backwards: never a switch
        reached = !elapsed[T] &&
                  (elapsed[T-1:0] >= {{(T-thtu_pkg::DELAY_W){1'b0}}, delay});
    end

    always_comb
    begin
        trigger_next     = trigger_reg;
        switch_time_next = switch_time_reg;
        edge_time_next   = edge_time_reg;
        rise_armed_next  = rise_armed_reg;
        fall_armed_next  = fall_armed_reg;
        rise_start_next  = rise_start_reg;
        fall_start_next  = fall_start_reg;
        if (item.kind == thtu_pkg::KIND_LOAD)
        begin
            trigger_next     = item.load_active;
            switch_time_next = item.load_switch_time;
            edge_time_next   = item.load_edge_time;
        end
        else if (!trigger_reg)
        begin
            fall_armed_next = 1'b0;
            if (crossed)
            begin
                rise_armed_next = 1'b1;
                rise_start_next = start;
                if (reached)
                begin
                    trigger_next     = 1'b1;
                    switch_time_next = item.sample_time;
                    edge_time_next   = start;
                end
            end
        end
        else
        begin
            rise_armed_next = 1'b0;
            if (crossed)
            begin
                fall_armed_next = 1'b1;
                fall_start_next = start;
                if (reached)
                begin
                    trigger_next     = 1'b0;
                    switch_time_next = item.sample_time;
                    edge_time_next   = start;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg     <= 1'b0;
            switch_time_reg <= '0;
            edge_time_reg   <= '0;
            rise_armed_reg  <= 1'b0;
            fall_armed_reg  <= 1'b0;
            rise_start_reg  <= '0;
            fall_start_reg  <= '0;
        end
        else if (step_en)
        begin
            trigger_reg     <= trigger_next;
            switch_time_reg <= switch_time_next;
            edge_time_reg   <= edge_time_next;
            rise_armed_reg  <= rise_armed_next;
            fall_armed_reg  <= fall_armed_next;
            rise_start_reg  <= rise_start_next;
            fall_start_reg  <= fall_start_next;
        end
    end

    assign result.active      = trigger_next;
    assign result.switch_time = switch_time_next;
    assign result.edge_time   = edge_time_next;

    assign status.trigger    = trigger_reg;
    assign status.rise_armed = rise_armed_reg;
    assign status.fall_armed = fall_armed_reg;

endmodule

`default_nettype wire

@@ src/timed_hysteresis_trigger_unit.sv @@
// Top level: stream ports, input register, trigger core and result register.
`default_nettype none

// Schmitt trigger with dwell time. Every input beat (a timestamped sample or
// a state load, selected by s_axis_tuser) yields exactly one result beat that
// carries the trigger state after that item. The unit takes one beat per
// clock and keeps that rate while the result register is drained every cycle;
// each beat passes the input register, then the result register, before the
// output handshake. The rate is set by the state update, one 64-bit subtract
// and 63-bit compare per item. Configuration writes are always ready and take
// effect on the next cycle; there is no clearing pass after reset.
module timed_hysteresis_trigger_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [thtu_pkg::CFG_W-1:0]        cfg_data,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample_time[62:0], sample_value[94:63], load_active[95],
    // load_switch_time[158:96], load_edge_time[221:159], zero[223:222]
    input  wire logic [thtu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // kind[0]
    input  wire logic [0:0]                        s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // active[0], switch_time[63:1], edge_time[126:64], zero[127]
    output logic [thtu_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    thtu_pkg::cfg_t     cfg;
    thtu_pkg::item_t    in_item;
    thtu_pkg::item_t    in_item_reg;
    logic               in_valid_reg;
    thtu_pkg::result_t  result;
    thtu_pkg::result_t  out_result_reg;
    logic               out_valid_reg;
    thtu_pkg::status_t  status;
    logic               fire;

    always_comb
    begin
        in_item.kind             = s_axis_tuser[0];
        in_item.sample_time      = s_axis_tdata[62:0];
        in_item.sample_value     = s_axis_tdata[94:63];
        in_item.load_active      = s_axis_tdata[95];
        in_item.load_switch_time = s_axis_tdata[158:96];
        in_item.load_edge_time   = s_axis_tdata[221:159];
    end

    // Advance the held beat whenever the result register is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    thtu_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    thtu_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result),
        .status  (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item;
        end
        if (fire)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_result_reg.edge_time,
                            out_result_reg.switch_time, out_result_reg.active};

    // A held beat waits until it is processed
    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg)
        else $error("input beat dropped before processing");

    // At most one side is armed
    a_one_armed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({status.rise_armed, status.fall_armed}))
        else $error("rise and fall armed together");

    // A switch on a sample stamps that sample's time
    a_switch_time: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_item_reg.kind == thtu_pkg::KIND_SAMPLE) &&
        (result.active != status.trigger)
        |=> m_axis_tdata[63:1] == $past(in_item_reg.sample_time))
        else $error("switch time differs from sample time");

endmodule

`default_nettype wire
